// File: rtl/chte_pkg.sv
// ----------------------------------------------------------------------------
// chte_pkg
// Shared types and constants for the chained hash table engine.
// ----------------------------------------------------------------------------
package chte_pkg;

  localparam int TABLE_SIZE_DEF = 1024;
  localparam int VALUE_BITS_DEF = 32;
  localparam int KEY_W          = 64;
  localparam int CMD_W          = 2;
  localparam int STATUS_W       = 3;
  localparam int CNT_W          = 11;
  localparam int VOUT_W         = 32;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd6;

  // divider request from the sequencer to the modulo unit
  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } chte_div_req_t;

endpackage

// File: rtl/chte_mod.sv
// ----------------------------------------------------------------------------
// chte_mod
// Bit-serial restoring remainder: one key bit per cycle.
// ----------------------------------------------------------------------------
module chte_mod
  import chte_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  chte_div_req_t    req,
  output logic             done,
  output logic [CNT_W-1:0] rem
);

  logic [KEY_W-1:0] sh_r, sh_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] dv_r, dv_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W:0]   trial;

  always_comb begin
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, sh_r[KEY_W-1]};
    if (req.start) begin
      sh_nxt   = req.dividend;
      dv_nxt   = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = 7'(KEY_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below divisor, so one compare and subtract
      if (trial >= {1'b0, dv_r}) rem_nxt = CNT_W'(trial - {1'b0, dv_r});
      else rem_nxt = CNT_W'(trial);
      sh_nxt  = {sh_r[KEY_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: rtl/chained_hash_table_engine_unit.sv
// ----------------------------------------------------------------------------
// chained_hash_table_engine_unit
// Separate-chaining hash table, 64-bit keys, node pool in on-chip memories.
// ----------------------------------------------------------------------------
// One command is taken at a time. After acceptance the bucket index is formed
// by a bit-serial remainder unit (S_DIV waits for its done flag), the bucket
// head is read in S_HEAD and S_HRD, then the chain is walked through the node
// memories node by node (read address in S_NRD, then compare in S_CMP), with a
// last S_NRD visit to see the end of the chain on a miss; the update states
// S_FREE, S_FRD and S_DONE follow before the result is offered. A refused or
// unused command goes from S_HRD straight to the result. After reset a clearing
// pass over all TABLE_SIZE entries empties the bucket heads and fills the free
// stack; no item is accepted during it.
module chained_hash_table_engine_unit
  import chte_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [10:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // key[63:0], value_in[95:64]
  input  logic [1:0]   in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata,  // status[2:0], value_out[34:3], entry_count[45:35]
  output logic         out_tuser   // unused, zero
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int NW = AW + 1;  // node link incl. null code TABLE_SIZE
  localparam logic [NW-1:0] NIL = NW'(TABLE_SIZE);
  localparam logic [NW-1:0] TS_N = NW'(TABLE_SIZE);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_HEAD = 4'd3;
  localparam logic [3:0] S_HRD  = 4'd4;
  localparam logic [3:0] S_NRD  = 4'd5;
  localparam logic [3:0] S_CMP  = 4'd6;
  localparam logic [3:0] S_FREE = 4'd7;
  localparam logic [3:0] S_FRD  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  // memories
  logic [NW-1:0]         head_mem [TABLE_SIZE];
  logic [KEY_W-1:0]      key_mem  [TABLE_SIZE];
  logic [VALUE_BITS-1:0] val_mem  [TABLE_SIZE];
  logic [NW-1:0]         next_mem [TABLE_SIZE];
  logic [AW-1:0]         free_mem [TABLE_SIZE];

  logic [NW-1:0]         head_q;
  logic [KEY_W-1:0]      key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [NW-1:0]         next_q;
  logic [AW-1:0]         free_q;

  logic [3:0]            st_r;
  logic [CNT_W-1:0]      bc_r;
  logic [CMD_W-1:0]      cmd_r;
  logic [KEY_W-1:0]      key_r;
  logic [VALUE_BITS-1:0] vin_r;
  logic [AW-1:0]         bkt_r;
  logic [NW-1:0]         cur_r, prev_r, hit_r;
  logic [NW:0]           steps_r;
  logic [NW-1:0]         free_top_r;
  logic [CNT_W-1:0]      held_r;
  logic [AW:0]           clr_r;
  logic [STATUS_W-1:0]   stat_r;
  logic [VOUT_W-1:0]     vout_r;
  logic                  found_r;

  logic [CNT_W-1:0] nb;
  always_comb begin
    if (bc_r == '0) nb = CNT_W'(1);
    else if ({{(32-CNT_W){1'b0}}, bc_r} > 32'(TABLE_SIZE)) nb = CNT_W'(TABLE_SIZE);
    else nb = bc_r;
  end

  chte_div_req_t dreq;
  logic          ddone;
  logic [CNT_W-1:0] drem;
  assign dreq.start    = in_tvalid && in_tready;
  assign dreq.dividend = in_tdata[63:0];
  assign dreq.divisor  = nb;

  chte_mod u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .done (ddone),
    .rem  (drem)
  );

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = {2'b00, held_r, vout_r, stat_r};
  assign out_tuser  = 1'b0;

  // memory control (combinational selection, clocked access)
  logic            hw_en, nw_en, kv_en, vw_en, fw_en;
  logic [AW-1:0]   h_wa, n_wa, kv_wa, f_wa, n_ra, f_ra;
  logic [NW-1:0]   h_wd, n_wd;
  logic [AW-1:0]   f_wd;
  logic [NW-1:0]   nn;  // node allocated on insert

  assign nn   = {1'b0, free_q};
  assign n_ra = cur_r[AW-1:0];
  assign f_ra = AW'(free_top_r - NW'(1));

  always_comb begin
    hw_en = 1'b0; nw_en = 1'b0; kv_en = 1'b0; vw_en = 1'b0; fw_en = 1'b0;
    h_wa = bkt_r; h_wd = NIL; n_wa = '0; n_wd = NIL; kv_wa = '0;
    f_wa = '0; f_wd = '0;
    if (st_r == S_CLR) begin
      hw_en = 1'b1; h_wa = clr_r[AW-1:0];
      fw_en = 1'b1; f_wa = clr_r[AW-1:0];
      f_wd  = AW'(TABLE_SIZE - 1) - clr_r[AW-1:0];
    end else if (st_r == S_FRD && cmd_r == CMD_INSERT && stat_r == ST_INSERTED
                 && hit_r != NIL) begin
      // tail link written in S_FRD, before the new node in S_DONE, one write port
      nw_en = 1'b1; n_wa = hit_r[AW-1:0]; n_wd = nn;
    end else if (st_r == S_DONE) begin
      if (cmd_r == CMD_INSERT && found_r) begin
        vw_en = 1'b1; kv_wa = hit_r[AW-1:0];
      end else if (cmd_r == CMD_INSERT && stat_r == ST_INSERTED) begin
        kv_en = 1'b1; vw_en = 1'b1; kv_wa = nn[AW-1:0];
        nw_en = 1'b1; n_wa = nn[AW-1:0]; n_wd = NIL;
        if (hit_r == NIL) begin
          hw_en = 1'b1; h_wd = nn;
        end
      end else if (cmd_r == CMD_REMOVE && stat_r == ST_REMOVED) begin
        if (prev_r == NIL) begin
          hw_en = 1'b1; h_wd = next_q;
        end else begin
          nw_en = 1'b1; n_wa = prev_r[AW-1:0]; n_wd = next_q;
        end
        if (free_top_r < TS_N) begin
          fw_en = 1'b1; f_wa = free_top_r[AW-1:0]; f_wd = hit_r[AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hw_en) head_mem[h_wa] <= h_wd;
    head_q <= head_mem[bkt_r];
    if (kv_en) key_mem[kv_wa] <= key_r;
    if (vw_en) val_mem[kv_wa] <= vin_r;
    key_q <= key_mem[n_ra];
    val_q <= val_mem[n_ra];
    if (nw_en) next_mem[n_wa] <= n_wd;
    next_q <= next_mem[n_ra];
    if (fw_en) free_mem[f_wa] <= f_wd;
    free_q <= free_mem[f_ra];
  end

  logic [VOUT_W-1:0] val_ext;
  assign val_ext = VOUT_W'({{(64-VALUE_BITS){1'b0}}, val_q});

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r <= in_tuser;
      key_r <= in_tdata[63:0];
      vin_r <= VALUE_BITS'(in_tdata[95:64]);
    end
    if (!rst_n) begin
      st_r       <= S_CLR;
      clr_r      <= '0;
      bc_r       <= CNT_W'(1024);
      free_top_r <= TS_N;
      held_r     <= '0;
    end else begin
      if (cfg_we) bc_r <= cfg_wdata;
      unique case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (AW+1)'(TABLE_SIZE - 1)) st_r <= S_IDLE;
        end
        S_IDLE: if (in_tvalid) st_r <= S_DIV;
        S_DIV: if (ddone) begin
          bkt_r <= AW'(drem);
          st_r  <= S_HEAD;
        end
        S_HEAD: st_r <= S_HRD;  // head read in flight
        S_HRD: begin
          cur_r <= head_q; prev_r <= NIL; hit_r <= NIL; steps_r <= '0;
          found_r <= 1'b0; vout_r <= '0; stat_r <= ST_MISSING;
          if (cmd_r == CMD_INSERT && held_r >= nb) begin
            stat_r <= ST_FULL; st_r <= S_OUT;
          end else if (cmd_r == CMD_REMOVE && held_r == '0) begin
            stat_r <= ST_EMPTY; st_r <= S_OUT;
          end else if (cmd_r != CMD_INSERT && cmd_r != CMD_REMOVE &&
                       cmd_r != CMD_LOOKUP) begin
            st_r <= S_OUT;
          end else st_r <= S_NRD;
        end
        S_NRD: begin
          if (cur_r < NIL && steps_r < {1'b0, TS_N}) st_r <= S_CMP;
          else st_r <= S_FREE;  // chain ended, miss
        end
        S_CMP: begin
          prev_r <= hit_r; hit_r <= cur_r;
          if (key_q == key_r) begin
            found_r <= 1'b1; st_r <= S_FREE;
          end else begin
            cur_r <= next_q; steps_r <= steps_r + 1'b1; st_r <= S_NRD;
          end
        end
        S_FREE: begin
          // free stack top is read continuously; node data of hit still at n_ra
          if (found_r) begin
            // next_q of the hit node: re-read after S_CMP left cur_r on hit
            unique case (cmd_r)
              CMD_INSERT: stat_r <= ST_REPLACED;
              CMD_REMOVE: stat_r <= ST_REMOVED;
              default: begin
                stat_r <= ST_FOUND; vout_r <= val_ext;
              end
            endcase
          end else if (cmd_r == CMD_INSERT) begin
            stat_r <= (free_top_r == '0) ? ST_FULL : ST_INSERTED;
          end
          st_r <= S_FRD;
        end
        S_FRD: st_r <= S_DONE;
        S_DONE: begin
          if (cmd_r == CMD_INSERT && stat_r == ST_INSERTED) begin
            free_top_r <= free_top_r - 1'b1; held_r <= held_r + 1'b1;
          end else if (cmd_r == CMD_REMOVE && stat_r == ST_REMOVED) begin
            if (free_top_r < TS_N) free_top_r <= free_top_r + 1'b1;
            held_r <= held_r - 1'b1;
          end
          st_r <= S_OUT;
        end
        S_OUT: if (out_tready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // the entry count never exceeds the pool
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {{(32-CNT_W){1'b0}}, held_r} <= 32'(TABLE_SIZE)) else $error("held overflow");
  // free nodes plus held entries cover the pool
  a_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> (32'(free_top_r) + 32'(held_r) == 32'(TABLE_SIZE)))
    else $error("pool accounting");
  // a refused insert leaves the count alone
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && stat_r == ST_FULL) |-> $stable(held_r)) else $error("full changed");

endmodule
